[sv/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// cond must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// ante at one edge implies cons at the next
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[sv/wgm_pkg.sv]
`timescale 1ns / 1ps

package wgm_pkg;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_TEXT   = 2'd2,
      FUNC_END    = 2'd3
   } func_type;

   typedef struct packed {
      func_type   func;
      logic [7:0] ch;
   } req_type;

   typedef struct packed {
      logic verdict_ready;
      logic matched;
      logic still_possible;
      logic pattern_full;
   } rsp_type;

   // register select, taken from paddr[2]
   localparam logic CSR_ANY_ONE = 1'b0;
   localparam logic CSR_ANY_RUN = 1'b1;

   localparam logic [7:0] ANY_ONE_RESET = 8'd63;
   localparam logic [7:0] ANY_RUN_RESET = 8'd42;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_STEP,
      CELL_CLOSE,
      CELL_REARM,
      CELL_APPEND
   } cell_op_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      cell_op_type op;
      logic [7:0]  ch;
      logic [7:0]  any_one;
      logic [7:0]  any_run;
   } cell_ctrl_type;

   // handed from a cell to its right neighbor
   typedef struct packed {
      logic adv;     // position advances on this text byte
      logic run_go;  // active star: next position reachable without text
   } link_type;

endpackage

[sv/wgm_cell.sv]
`timescale 1ns / 1ps

module wgm_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wgm_pkg::cell_ctrl_type ctrl,
   input  logic [CNT_W-1:0]      count,
   input  wgm_pkg::link_type     left,
   output wgm_pkg::link_type     right,
   output logic                  active,
   output logic                  pend
);
   import wgm_pkg::*;

   logic [7:0] pat_ff, pat_in;
   logic       active_ff, active_in;
   logic       in_use, is_run, hit;

   assign in_use = count > CNT_W'(INDEX);
   // equal codes: the byte acts as the single-byte wildcard
   assign is_run = (pat_ff == ctrl.any_run) && (pat_ff != ctrl.any_one);
   assign hit    = (pat_ff == ctrl.any_one) || (pat_ff == ctrl.ch);

   assign right.run_go = active_ff & in_use & is_run;
   assign right.adv    = active_ff & in_use & ~is_run & hit;
   assign active       = active_ff;
   // left star would turn this position on: closure not done yet
   assign pend         = left.run_go & ~active_ff;

   always_comb begin
      pat_in    = pat_ff;
      active_in = active_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
         end
         CELL_STEP: begin
            active_in = left.adv | right.run_go;
         end
         CELL_CLOSE: begin
            active_in = active_ff | left.run_go;
         end
         CELL_REARM: begin
            active_in = (INDEX == 0);
         end
         CELL_APPEND: begin
            active_in = (INDEX == 0);
            if (count == CNT_W'(INDEX)) begin
               pat_in = ctrl.ch;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= (INDEX == 0);
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
   end

endmodule

[sv/wildcard_glob_matcher.sv]
// An accepted item's result reaches the output register after the star-closure
// passes in ST_CLOSE; there are none unless stars newly become active, and none
// for a refused append. A stalled output register holds the controller.
// No new item is taken before the result is handed on. Each closure pass moves one
// pattern cell along the chain, so there are at most as many passes as stars in the run.
// Reset (synchronous): empty pattern, position zero active, codes '?' and '*'.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wildcard_glob_matcher #(
   parameter int PATTERN_MAX = 64
) (
   input  logic              clock,
   input  logic              reset,
   // input items
   input  logic              req_valid,
   output logic              req_stall,
   input  wgm_pkg::req_type  req_data,
   // result items
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wgm_pkg::rsp_type  rsp_data,
   // configuration
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import wgm_pkg::*;

   localparam int CNT_W = $clog2(PATTERN_MAX + 1);

   typedef enum logic {
      ST_IDLE,   // ready for an item
      ST_CLOSE   // star closure passes, then hand result to output register
   } state_type;

   // ---------------------------------------------------------------
   // Configuration registers: wildcard codes
   // ---------------------------------------------------------------
   logic [7:0] any_one_ff, any_run_ff;
   logic       csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;
   assign prdata = {24'd0, (paddr[2] == CSR_ANY_RUN) ? any_run_ff : any_one_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         any_one_ff <= ANY_ONE_RESET;
         any_run_ff <= ANY_RUN_RESET;
      end else if (csr_wr) begin
         if (paddr[2] == CSR_ANY_ONE) begin
            any_one_ff <= pwdata[7:0];
         end else begin
            any_run_ff <= pwdata[7:0];
         end
      end
   end

   // ---------------------------------------------------------------
   // Controller state
   // ---------------------------------------------------------------
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             last_ff, last_in;        // active bit of position PATTERN_MAX
   logic             verdict_ff, verdict_in;  // payload of the item in flight
   logic             matched_ff, matched_in;
   logic             full_ff, full_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             req_acc;
   cell_ctrl_type    ctrl;
   logic             pending;
   logic             any_active;
   logic             pat_full;
   logic             rsp_verdict;

   // chain wiring: lnk[j] enters cell j, pos[j] is position j's active bit
   link_type               lnk  [PATTERN_MAX:0];
   logic [PATTERN_MAX:0]   pos;
   logic [PATTERN_MAX-1:0] pend_vec;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rsp_verdict = rsp_valid_ff & rsp_data_ff.verdict_ready;

   assign pat_full   = (count_ff == CNT_W'(PATTERN_MAX));
   assign pos[PATTERN_MAX] = last_ff;
   // a code write can leave the vector open; only a stepped, rearmed or appended one is closed
   assign pending    = (|pend_vec) | (lnk[PATTERN_MAX].run_go & ~last_ff);
   // positions above the count stay clear, so the plain OR is exact
   assign any_active = |pos;

   assign lnk[0] = '0;

   // ---------------------------------------------------------------
   // Cell row: one cell per pattern byte
   // ---------------------------------------------------------------
   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      wgm_cell #(
         .INDEX (j),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .count  (count_ff),
         .left   (lnk[j]),
         .right  (lnk[j+1]),
         .active (pos[j]),
         .pend   (pend_vec[j])
      );
   end

   // ---------------------------------------------------------------
   // Next-state logic
   // ---------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      verdict_in   = verdict_ff;
      matched_in   = matched_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;

      ctrl.op      = CELL_HOLD;
      ctrl.ch      = req_data.ch;
      ctrl.any_one = any_one_ff;
      ctrl.any_run = any_run_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in   = ST_CLOSE;
               verdict_in = 1'b0;
               matched_in = 1'b0;
               full_in    = 1'b0;
               unique case (req_data.func)
                  FUNC_CLEAR: begin
                     ctrl.op  = CELL_REARM;
                     count_in = '0;
                     last_in  = 1'b0;
                  end
                  FUNC_APPEND: begin
                     if (pat_full) begin
                        full_in = 1'b1;   // dropped, state unchanged
                     end else begin
                        ctrl.op  = CELL_APPEND;
                        count_in = count_ff + CNT_W'(1);
                        last_in  = 1'b0;
                     end
                  end
                  FUNC_TEXT: begin
                     ctrl.op = CELL_STEP;
                     last_in = lnk[PATTERN_MAX].adv;
                  end
                  FUNC_END: begin
                     ctrl.op    = CELL_REARM;
                     verdict_in = 1'b1;
                     matched_in = pos[count_ff];
                     last_in    = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CLOSE: begin
            if (pending && !full_ff) begin
               // one closure pass: each active star lights its right neighbor
               ctrl.op = CELL_CLOSE;
               last_in = last_ff | lnk[PATTERN_MAX].run_go;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               state_in                   = ST_IDLE;
               rsp_valid_in               = 1'b1;
               rsp_data_in.verdict_ready  = verdict_ff;
               rsp_data_in.matched        = matched_ff;
               rsp_data_in.still_possible = any_active;
               rsp_data_in.pattern_full   = full_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      verdict_ff  <= verdict_in;
      matched_ff  <= matched_in;
      full_ff     <= full_in;
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CNT_W'(PATTERN_MAX), "count overflow")
   `ASSERT_NEXT(a_end_rearm, clock, reset, req_acc && req_data.func == FUNC_END, pos[0], "rearm")
   `ASSERT_ALWAYS(a_verdict_live, clock, reset, !rsp_verdict || rsp_data_ff.still_possible, "dead")

endmodule
